FILE: rtl/pgc_pkg.sv
// ============================================================================
// pgc_pkg
// Shared types and constants of the pairwise gravity and Coulomb force summer.
// ============================================================================
package pgc_pkg;

    localparam int SEP_W      = 33;
    localparam int DIST_W     = 34;
    localparam int D2_W       = 66;
    localparam int NUM_W      = 98;
    localparam int SUM_W      = 48;
    localparam int DIV_STEP   = 7;
    localparam int DIV_CYCLES = NUM_W / DIV_STEP;
    localparam int SQRT_STEP  = 2;
    localparam int SQRT_CYCLES = DIST_W / SQRT_STEP;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_GRAVITY  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_ELECTRIC = 1'b1;
    localparam logic [31:0]          COEF_RESET   = 32'd65536;

    typedef struct packed {
        logic               start_sum;
        logic signed [31:0] self_x;
        logic signed [31:0] self_y;
        logic signed [31:0] self_z;
        logic signed [31:0] peer_x;
        logic signed [31:0] peer_y;
        logic signed [31:0] peer_z;
        logic        [31:0] self_mass;
        logic        [31:0] peer_mass;
        logic signed [31:0] self_charge;
        logic signed [31:0] peer_charge;
    } pair_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] sum_z;
        logic                    zero_distance;
        logic                    saturated;
    } force_item_t;

    typedef struct packed {
        logic                       start_sum;
        logic [2:0][SEP_W-1:0]      mag;
        logic [2:0]                 neg;
        logic [31:0]                mass_a;
        logic [31:0]                mass_b;
        logic [31:0]                charge_a;
        logic [31:0]                charge_b;
        logic                       charge_neg;
    } job_t;

endpackage

FILE: rtl/pgc_sqrt.sv
// ============================================================================
// pgc_sqrt
// Iterative integer square root, two result bits per cycle.
// ============================================================================
module pgc_sqrt
    import pgc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [D2_W-1:0]   value,
    output logic              done,
    output logic [DIST_W-1:0] root
);

    localparam int CNT_W = $clog2(SQRT_CYCLES + 1);

    logic [2*DIST_W-1:0] val_reg, val_next;
    logic [DIST_W+2:0]   rem_reg, rem_next;
    logic [DIST_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    always_comb
    begin
        logic [DIST_W+2:0] shifted;
        logic [DIST_W+2:0] trial;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        for (int i = 0; i < SQRT_STEP; i++)
        begin
            shifted  = {rem_next[DIST_W:0], val_next[2*DIST_W-1 -: 2]};
            trial    = {1'b0, root_next, 2'b01};
            val_next = {val_next[2*DIST_W-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_next[DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_next[DIST_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= {{(2*DIST_W-D2_W){1'b0}}, value};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= val_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: rtl/pgc_div.sv
// ============================================================================
// pgc_div
// Restoring divider of a wide numerator by the distance, several bits a cycle.
// ============================================================================
module pgc_div
    import pgc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DIST_W-1:0] den,
    output logic              done,
    output logic [NUM_W-1:0]  quo
);

    localparam int CNT_W = $clog2(DIV_CYCLES + 1);

    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DIST_W:0]   rem_reg, rem_next;
    logic [DIST_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    always_comb
    begin
        logic [DIST_W:0] shifted;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            shifted  = {rem_next[DIST_W-1:0], quo_next[NUM_W-1]};
            quo_next = {quo_next[NUM_W-2:0], 1'b0};
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next    = shifted - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = shifted;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: rtl/pgc_front.sv
// ============================================================================
// pgc_front
// Takes pair items, forms separations and charge signs, queues the jobs.
// ============================================================================
module pgc_front
    import pgc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  pair_item_t pair,
    output logic       job_valid,
    input  logic       job_take,
    output job_t       job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    job_t             job_in;
    logic             push_ok;

    function automatic logic [SEP_W:0] axis_sep(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [SEP_W-1:0] diff;
        logic        [SEP_W-1:0] mag;
        diff = {b[31], b} - {a[31], a};
        mag  = diff[SEP_W-1] ? SEP_W'(-diff) : SEP_W'(diff);
        return {diff[SEP_W-1], mag};
    endfunction

    function automatic logic [31:0] abs32(logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    always_comb
    begin
        logic [SEP_W:0] sx, sy, sz;
        sx = axis_sep(pair.self_x, pair.peer_x);
        sy = axis_sep(pair.self_y, pair.peer_y);
        sz = axis_sep(pair.self_z, pair.peer_z);
        job_in.start_sum  = pair.start_sum;
        job_in.mag[0]     = sx[SEP_W-1:0];
        job_in.mag[1]     = sy[SEP_W-1:0];
        job_in.mag[2]     = sz[SEP_W-1:0];
        job_in.neg        = {sz[SEP_W], sy[SEP_W], sx[SEP_W]};
        job_in.mass_a     = pair.self_mass;
        job_in.mass_b     = pair.peer_mass;
        job_in.charge_a   = abs32(pair.self_charge);
        job_in.charge_b   = abs32(pair.peer_charge);
        job_in.charge_neg = pair.self_charge[31] ^ pair.peer_charge[31];
    end

    assign full      = count_reg == CNT_W'(DEPTH);
    assign push_ok   = push && !full;
    assign job_valid = count_reg != '0;
    assign job       = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (job_take && job_valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push_ok && !(job_take && job_valid))
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (!push_ok && job_take && job_valid)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            store_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

FILE: rtl/pgc_back.sv
// ============================================================================
// pgc_back
// Sequencer: products, distance, divisions and saturating force sums.
// ============================================================================
module pgc_back
    import pgc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] gravity_coef,
    input  logic [31:0] electric_coef,
    input  logic        job_valid,
    output logic        job_take,
    input  job_t        job,
    output logic        empty,
    input  logic        pop,
    output force_item_t result
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_MUL  = 10'b0000000010,
        ST_NUM  = 10'b0000000100,
        ST_SQRT = 10'b0000001000,
        ST_DIV1 = 10'b0000010000,
        ST_DIV2 = 10'b0000100000,
        ST_CMUL = 10'b0001000000,
        ST_CDIV = 10'b0010000000,
        ST_ACC  = 10'b0100000000,
        ST_OUT  = 10'b1000000000
    } state_t;

    localparam logic [48:0]           CAP     = 49'h1_0000_0000_0000;
    localparam logic signed [SUM_W+1:0] SUM_MAX = (SUM_W+2)'(48'sh7FFF_FFFF_FFFF);
    localparam logic signed [SUM_W+1:0] SUM_MIN = -(SUM_W+2)'(48'sh7FFF_FFFF_FFFF) - 1;

    state_t                  state_reg;
    logic [3:0]              step_reg;
    logic [1:0]              comp_reg;
    job_t                    job_reg;
    logic [2*SEP_W-1:0]      prod_reg;
    logic [D2_W-1:0]         d2_reg;
    logic [63:0]             gm_reg;
    logic [62:0]             qq_reg;
    logic [95:0]             ga_reg;
    logic [95:0]             eb_reg;
    logic [NUM_W-1:0]        nmag_reg;
    logic                    nneg_reg;
    logic [DIST_W-1:0]       d_reg;
    logic [NUM_W-1:0]        u_reg;
    logic [NUM_W-1:0]        cprod_reg;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic                    zero_reg;
    logic                    sat_reg;
    logic                    sq_start_reg;
    logic                    dv_start_reg;
    logic [NUM_W-1:0]        dv_num_reg;
    force_item_t             out_reg;
    logic                    out_valid_reg;

    logic [SEP_W-1:0]        mul_a;
    logic [SEP_W-1:0]        mul_b;
    logic                    sq_done;
    logic [DIST_W-1:0]       sq_root;
    logic                    dv_done;
    logic [NUM_W-1:0]        dv_quo;
    logic [NUM_W-1:0]        num_sum;
    logic [48:0]             w_cap;
    logic signed [SUM_W+1:0] contrib;
    logic signed [SUM_W+1:0] total;

    pgc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start_reg),
        .value (d2_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    pgc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start_reg),
        .num   (dv_num_reg),
        .den   (d_reg),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL)
        begin
            case (step_reg)
                4'd0:
                begin
                    mul_a = job_reg.mag[0];
                    mul_b = job_reg.mag[0];
                end
                4'd1:
                begin
                    mul_a = job_reg.mag[1];
                    mul_b = job_reg.mag[1];
                end
                4'd2:
                begin
                    mul_a = job_reg.mag[2];
                    mul_b = job_reg.mag[2];
                end
                4'd3:
                begin
                    mul_a = {1'b0, gravity_coef};
                    mul_b = {1'b0, job_reg.mass_a};
                end
                4'd4:
                begin
                    mul_a = {1'b0, job_reg.charge_a};
                    mul_b = {1'b0, job_reg.charge_b};
                end
                4'd5:
                begin
                    mul_a = {1'b0, gm_reg[31:0]};
                    mul_b = {1'b0, job_reg.mass_b};
                end
                4'd6:
                begin
                    mul_a = {1'b0, gm_reg[63:32]};
                    mul_b = {1'b0, job_reg.mass_b};
                end
                4'd7:
                begin
                    mul_a = {1'b0, qq_reg[31:0]};
                    mul_b = {1'b0, electric_coef};
                end
                4'd8:
                begin
                    mul_a = {2'b00, qq_reg[62:32]};
                    mul_b = {1'b0, electric_coef};
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == ST_CMUL)
        begin
            mul_b = job_reg.mag[comp_reg];
            case (step_reg)
                4'd0:    mul_a = u_reg[32:0];
                4'd1:    mul_a = u_reg[65:33];
                4'd2:    mul_a = {1'b0, u_reg[97:66]};
                default: mul_a = '0;
            endcase
        end
    end

    // sum of the gravity and Coulomb numerator terms, and the force term capped at 2^48
    assign num_sum = NUM_W'(ga_reg) + NUM_W'(eb_reg);
    assign w_cap   = (dv_quo > NUM_W'(CAP)) ? CAP : dv_quo[48:0];

    always_comb
    begin
        logic [SUM_W+1:0] cmag;
        cmag    = {1'b0, w_cap};
        contrib = (nneg_reg ^ job_reg.neg[comp_reg]) ? $signed((SUM_W+2)'(0) - cmag)
                                                     : $signed(cmag);
        total   = {{2{sum_reg[comp_reg][SUM_W-1]}}, sum_reg[comp_reg]} + contrib;
    end

    assign job_take = (state_reg == ST_IDLE) && job_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            comp_reg      <= '0;
            sq_start_reg  <= 1'b0;
            dv_start_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            sq_start_reg <= 1'b0;
            dv_start_reg <= 1'b0;
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        step_reg <= '0;
                        if (job.start_sum)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                sum_reg[i] <= '0;
                            end
                        end
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd9)
                    begin
                        state_reg <= ST_NUM;
                    end
                end
                ST_NUM:
                begin
                    if (d2_reg == '0)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        sq_start_reg <= 1'b1;
                        state_reg    <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (sq_done)
                    begin
                        dv_start_reg <= 1'b1;
                        state_reg    <= ST_DIV1;
                    end
                end
                ST_DIV1:
                begin
                    if (dv_done)
                    begin
                        dv_start_reg <= 1'b1;
                        state_reg    <= ST_DIV2;
                    end
                end
                ST_DIV2:
                begin
                    if (dv_done)
                    begin
                        comp_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_CMUL;
                    end
                end
                ST_CMUL:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd3)
                    begin
                        dv_start_reg <= 1'b1;
                        state_reg    <= ST_CDIV;
                    end
                end
                ST_CDIV:
                begin
                    if (dv_done)
                    begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    if (total > SUM_MAX)
                    begin
                        sum_reg[comp_reg] <= SUM_MAX[SUM_W-1:0];
                    end
                    else if (total < SUM_MIN)
                    begin
                        sum_reg[comp_reg] <= SUM_MIN[SUM_W-1:0];
                    end
                    else
                    begin
                        sum_reg[comp_reg] <= total[SUM_W-1:0];
                    end
                    if (comp_reg == 2'd2)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        step_reg  <= '0;
                        state_reg <= ST_CMUL;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                job_reg <= job;
                d2_reg  <= '0;
                ga_reg  <= '0;
                eb_reg  <= '0;
                sat_reg <= 1'b0;
            end
            ST_MUL:
            begin
                case (step_reg)
                    4'd1, 4'd2, 4'd3: d2_reg <= d2_reg + prod_reg;
                    4'd4:             gm_reg <= prod_reg[63:0];
                    4'd5:             qq_reg <= prod_reg[62:0];
                    4'd6:             ga_reg <= ga_reg + {32'd0, prod_reg[63:0]};
                    4'd7:             ga_reg <= ga_reg + {prod_reg[63:0], 32'd0};
                    4'd8:             eb_reg <= eb_reg + {32'd0, prod_reg[63:0]};
                    4'd9:             eb_reg <= eb_reg + {prod_reg[63:0], 32'd0};
                    default:          d2_reg <= d2_reg;
                endcase
            end
            ST_NUM:
            begin
                zero_reg <= d2_reg == '0;
                if (job_reg.charge_neg)
                begin
                    nmag_reg <= num_sum;
                    nneg_reg <= 1'b0;
                end
                else if (ga_reg >= eb_reg)
                begin
                    nmag_reg <= NUM_W'(ga_reg - eb_reg);
                    nneg_reg <= 1'b0;
                end
                else
                begin
                    nmag_reg <= NUM_W'(eb_reg - ga_reg);
                    nneg_reg <= 1'b1;
                end
            end
            ST_SQRT:
            begin
                d_reg      <= sq_root;
                dv_num_reg <= nmag_reg;
            end
            ST_DIV1:
            begin
                dv_num_reg <= dv_quo;
            end
            ST_DIV2:
            begin
                u_reg     <= dv_quo;
                cprod_reg <= '0;
            end
            ST_CMUL:
            begin
                case (step_reg)
                    4'd1:    cprod_reg <= cprod_reg + NUM_W'(prod_reg);
                    4'd2:    cprod_reg <= cprod_reg + NUM_W'({prod_reg, 33'd0});
                    4'd3:    dv_num_reg <= cprod_reg + NUM_W'({prod_reg, 66'd0});
                    default: cprod_reg <= cprod_reg;
                endcase
            end
            ST_ACC:
            begin
                cprod_reg <= '0;
                if (total > SUM_MAX || total < SUM_MIN)
                begin
                    sat_reg <= 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_reg.sum_x         <= sum_reg[0];
                    out_reg.sum_y         <= sum_reg[1];
                    out_reg.sum_z         <= sum_reg[2];
                    out_reg.zero_distance <= zero_reg;
                    out_reg.saturated     <= sat_reg;
                end
            end
            default:
            begin
                cprod_reg <= cprod_reg;
            end
        endcase
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

FILE: rtl/pairwise_gravity_coulomb_force_sum_core.sv
// ============================================================================
// pairwise_gravity_coulomb_force_sum_core
// Gravity and Coulomb pair forces added into a saturating 3-D force sum.
//
//   channel   handshake           payload
//   pair      push / full         pair_item_t
//   result    empty / pop         force_item_t
//   config    wr_en               wr_index, wr_data
//
// one pair runs through the shared square root unit and
// five passes of the shared divider (seven quotient bits a cycle)
// a coincident pair skips the square root and the divider
// the job queue takes further pairs while the sequencer runs or a result waits
// reset clears the force sums, queue and result; coefficients return to 1.0
// ============================================================================
module pairwise_gravity_coulomb_force_sum_core
    import pgc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  pair_item_t           pair,
    output logic                 empty,
    input  logic                 pop,
    output force_item_t          result,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [31:0]          wr_data
);

    logic [31:0] gravity_reg;
    logic [31:0] electric_reg;
    logic        job_valid;
    logic        job_take;
    job_t        job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg  <= COEF_RESET;
            electric_reg <= COEF_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_GRAVITY:  gravity_reg  <= wr_data;
                REG_ELECTRIC: electric_reg <= wr_data;
                default:      gravity_reg  <= gravity_reg;
            endcase
        end
    end

    pgc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pair      (pair),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    pgc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .gravity_coef  (gravity_reg),
        .electric_coef (electric_reg),
        .job_valid     (job_valid),
        .job_take      (job_take),
        .job           (job),
        .empty         (empty),
        .pop           (pop),
        .result        (result)
    );

endmodule

FILE: tb/tb_pairwise_gravity_coulomb_force_sum_core.sv
// ============================================================================
// tb_pairwise_gravity_coulomb_force_sum_core
// Self-checking bench for the pairwise gravity and Coulomb force summer.
// Directed rows: coincident pairs, clipping at both sum limits; then pairs at
// coefficient extremes and random pairs over several coefficient settings and
// idle patterns. Each result is checked against a typed value or bit-exact model.
// ============================================================================
`timescale 1ns / 1ps

module tb_pairwise_gravity_coulomb_force_sum_core;
    import pgc_pkg::*;

    localparam longint SUM_HI      = 64'sd140737488355327;
    localparam longint SUM_LO      = -64'sd140737488355328;
    localparam int     CYCLE_LIMIT = 2000000;
    localparam int     DRAIN_WAIT  = 300;
    localparam int     PHASE_ITEMS = 260;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    pair_item_t  pair;
    logic        empty;
    logic        pop;
    force_item_t result;
    logic        wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [31:0] wr_data;

    pairwise_gravity_coulomb_force_sum_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .pair     (pair),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    logic [31:0] grav_coef;
    logic [31:0] elec_coef;
    longint      force_acc [3];
    force_item_t force_q [$];

    int errors;
    int checked;
    int zero_seen;
    int sat_seen;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    typedef struct {
        pair_item_t  p;
        bit          typed;
        force_item_t f;
    } stim_row_t;

    stim_row_t dir_rows [$];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic force_item_t predict_force(pair_item_t p);
        logic signed [32:0] sep [3];
        logic [32:0]  mag [3];
        logic [65:0]  d2;
        logic [33:0]  root_d;
        logic [67:0]  tt;
        logic [63:0]  gm;
        logic [31:0]  q1m;
        logic [31:0]  q2m;
        logic [127:0] ga;
        logic [127:0] eb;
        logic [127:0] nmag;
        logic [127:0] quo;
        logic [127:0] w;
        logic [129:0] prod;
        logic [48:0]  wm;
        bit           qneg;
        bit           nneg;
        bit           sat;
        longint       c;
        longint       s;
        force_item_t  f;

        sep[0] = {p.peer_x[31], p.peer_x} - {p.self_x[31], p.self_x};
        sep[1] = {p.peer_y[31], p.peer_y} - {p.self_y[31], p.self_y};
        sep[2] = {p.peer_z[31], p.peer_z} - {p.self_z[31], p.self_z};
        for (int i = 0; i < 3; i++)
            mag[i] = sep[i][32] ? -sep[i] : sep[i];
        if (p.start_sum)
            for (int i = 0; i < 3; i++)
                force_acc[i] = 0;
        d2 = 66'(mag[0]) * 66'(mag[0]) + 66'(mag[1]) * 66'(mag[1])
           + 66'(mag[2]) * 66'(mag[2]);
        sat = 1'b0;
        if (d2 != 0)
        begin
            root_d = '0;
            for (int b = 33; b >= 0; b--)
            begin
                tt = 68'(root_d | (34'd1 << b));
                tt = tt * tt;
                if (tt <= 68'(d2))
                    root_d = root_d | (34'd1 << b);
            end
            gm   = 64'(grav_coef) * 64'(p.self_mass);
            ga   = 128'(gm) * 128'(p.peer_mass);
            q1m  = p.self_charge[31] ? -p.self_charge : p.self_charge;
            q2m  = p.peer_charge[31] ? -p.peer_charge : p.peer_charge;
            eb   = 128'(elec_coef) * (128'(q1m) * 128'(q2m));
            qneg = p.self_charge[31] != p.peer_charge[31];
            nneg = 1'b0;
            if (qneg)
                nmag = ga + eb;
            else if (ga >= eb)
                nmag = ga - eb;
            else
            begin
                nmag = eb - ga;
                nneg = 1'b1;
            end
            quo = nmag / 128'(root_d);
            quo = quo / 128'(root_d);
            for (int i = 0; i < 3; i++)
            begin
                prod = 130'(quo) * 130'(mag[i]);
                w    = prod[127:0] / 128'(root_d);
                wm   = (w > 128'(1) << 48) ? 49'(1) << 48 : w[48:0];
                c    = longint'({15'b0, wm});
                if (nneg != sep[i][32])
                    c = -c;
                s = force_acc[i] + c;
                if (s > SUM_HI)
                begin
                    s   = SUM_HI;
                    sat = 1'b1;
                end
                if (s < SUM_LO)
                begin
                    s   = SUM_LO;
                    sat = 1'b1;
                end
                force_acc[i] = s;
            end
        end
        f.sum_x         = force_acc[0][47:0];
        f.sum_y         = force_acc[1][47:0];
        f.sum_z         = force_acc[2][47:0];
        f.zero_distance = (d2 == 0);
        f.saturated     = sat;
        return f;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0004_0000);
            2: return -$urandom_range(0, 32'h0004_0000);
            default: return $urandom_range(0, 32'h0000_0400);
        endcase
    endfunction

    function automatic pair_item_t rand_pair();
        pair_item_t p;
        int kind;

        kind = $urandom_range(0, 9);
        p.start_sum   = ($urandom_range(0, 7) == 0);
        p.self_x      = $urandom();
        p.self_y      = $urandom();
        p.self_z      = $urandom();
        p.self_mass   = rand_word();
        p.peer_mass   = rand_word();
        p.self_charge = rand_word();
        p.peer_charge = rand_word();
        if (kind == 0)
        begin
            p.peer_x = $urandom();
            p.peer_y = $urandom();
            p.peer_z = $urandom();
        end
        else if (kind == 1)
        begin
            p.peer_x = p.self_x;
            p.peer_y = p.self_y;
            p.peer_z = p.self_z;
        end
        else
        begin
            p.peer_x = p.self_x + rand_word();
            p.peer_y = p.self_y + rand_word();
            p.peer_z = p.self_z + rand_word();
        end
        return p;
    endfunction

    task automatic send_pair(input pair_item_t p, input bit typed, input force_item_t tv);
        int gap;
        force_item_t f;

        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        pair <= p;
        do
            @(posedge clk);
        while (full);
        f = predict_force(p);
        force_q.push_back(typed ? tv : f);
    endtask

    task automatic wait_idle();
        while (force_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_coefs(input logic [31:0] g, input logic [31:0] e);
        wr_en    <= 1'b1;
        wr_index <= REG_GRAVITY;
        wr_data  <= g;
        @(posedge clk);
        wr_index <= REG_ELECTRIC;
        wr_data  <= e;
        @(posedge clk);
        wr_en    <= 1'b0;
        grav_coef = g;
        elec_coef = e;
    endtask

    function automatic stim_row_t mk_row(bit st, int px, int py, int pz, int sx, int sy,
                                         int sz, logic [31:0] m1, logic [31:0] m2,
                                         logic [31:0] q1, logic [31:0] q2);
        stim_row_t r;

        r.p.start_sum   = st;
        r.p.self_x      = sx;
        r.p.self_y      = sy;
        r.p.self_z      = sz;
        r.p.peer_x      = px;
        r.p.peer_y      = py;
        r.p.peer_z      = pz;
        r.p.self_mass   = m1;
        r.p.peer_mass   = m2;
        r.p.self_charge = q1;
        r.p.peer_charge = q2;
        r.typed         = 1'b0;
        r.f             = '0;
        return r;
    endfunction

    always @(posedge clk)
    begin
        force_item_t exp_f;

        if (rst_n && pop && !empty)
        begin
            if (force_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item actual=%h", $realtime, result);
            end
            else
            begin
                exp_f = force_q.pop_front();
                checked++;
                zero_seen += result.zero_distance;
                sat_seen  += result.saturated;
                if (result.sum_x !== exp_f.sum_x || result.sum_y !== exp_f.sum_y
                    || result.sum_z !== exp_f.sum_z
                    || result.zero_distance !== exp_f.zero_distance
                    || result.saturated !== exp_f.saturated)
                begin
                    errors++;
                    if (errors <= 30)
                        $display("%0t: mismatch expected=%h/%h/%h z%b s%b actual=%h/%h/%h z%b s%b",
                                 $realtime, exp_f.sum_x, exp_f.sum_y, exp_f.sum_z,
                                 exp_f.zero_distance, exp_f.saturated, result.sum_x,
                                 result.sum_y, result.sum_z, result.zero_distance,
                                 result.saturated);
                end
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        stim_row_t r;
        int        phase_g [4];
        int        phase_e [4];
        int        phase_s [4];
        int        phase_r [4];

        rst_n          = 1'b0;
        push           = 1'b0;
        pair           = '0;
        wr_en          = 1'b0;
        wr_index       = REG_GRAVITY;
        wr_data        = '0;
        pop            = 1'b0;
        errors         = 0;
        checked        = 0;
        zero_seen      = 0;
        sat_seen       = 0;
        cycles         = 0;
        hold_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        grav_coef      = COEF_RESET;
        elec_coef      = COEF_RESET;
        for (int i = 0; i < 3; i++)
            force_acc[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coincident pair straight after reset
        r = mk_row(1, 5, 6, 7, 5, 6, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        r.typed = 1'b1;
        r.f.zero_distance = 1'b1;
        dir_rows.push_back(r);
        // unit separation with full masses clips high, then low
        r = mk_row(1, 1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        r.typed = 1'b1;
        r.f.sum_x = 48'h7FFF_FFFF_FFFF;
        r.f.saturated = 1'b1;
        dir_rows.push_back(r);
        r = mk_row(1, -1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        r.typed = 1'b1;
        r.f.sum_x = 48'h8000_0000_0000;
        r.f.saturated = 1'b1;
        dir_rows.push_back(r);
        dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1));
        dir_rows.push_back(mk_row(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                                  32'h8000_0000));
        dir_rows.push_back(mk_row(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        dir_rows.push_back(mk_row(1, 65536, 0, 0, 0, 0, 0, 65536, 65536, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 65536, 0, 0, 0, 0, 65536, 65536, 65536, 65536));
        dir_rows.push_back(mk_row(0, 0, 0, -65536, 0, 0, 0, 0, 0, 65536, -65536));
        dir_rows.push_back(mk_row(0, 3 << 16, 4 << 16, 0, 0, 0, 0, 2 << 16, 5 << 16,
                                  -(3 << 16), -(1 << 16)));
        dir_rows.push_back(mk_row(0, 100, -200, 300, 100, -200, 300, 7, 7, 7, 7));
        dir_rows.push_back(mk_row(1, 12345, -54321, 777, -4, 9, 1 << 20, 1 << 20,
                                  1 << 18, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        foreach (dir_rows[k])
            send_pair(dir_rows[k].p, dir_rows[k].typed, dir_rows[k].f);
        push <= 1'b0;

        // extreme coefficients on a few pairs
        wait_idle();
        set_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(mk_row(1, 1 << 16, 1 << 16, 1 << 16, 0, 0, 0, 32'hFFFF_FFFF, 3,
                         32'h8000_0000, 5).p, 1'b0, '0);
        send_pair(mk_row(0, -(1 << 24), 9, 0, 0, 0, 0, 1 << 16, 1 << 16,
                         1 << 16, 1 << 16).p, 1'b0, '0);
        push <= 1'b0;
        wait_idle();
        set_coefs(0, 0);
        send_pair(mk_row(1, 1, 2, 3, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'h7FFF_FFFF, 32'h8000_0000).p, 1'b0, '0);
        push <= 1'b0;

        phase_g = '{COEF_RESET, 32'hFFFF_FFFF, 0, $urandom()};
        phase_e = '{COEF_RESET, 0, 32'hFFFF_FFFF, $urandom()};
        phase_s = '{0, 73, 0, 6};
        phase_r = '{0, 0, 73, 6};
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            set_coefs(phase_g[ph], phase_e[ph]);
            send_idle_pct  = phase_s[ph];
            recv_stall_pct = phase_r[ph];
            if (ph == 0)
                hold_cycles = 1500;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pair(rand_pair(), 1'b0, '0);
            push <= 1'b0;
        end

        while (force_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("checked %0d force items over four coefficient settings and idle patterns",
                 checked);
        $display("coincident pairs %0d, clipped sums %0d", zero_seen, sat_seen);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pgc_pkg.sv
rtl/pgc_sqrt.sv
rtl/pgc_div.sv
rtl/pgc_front.sv
rtl/pgc_back.sv
rtl/pairwise_gravity_coulomb_force_sum_core.sv
tb/tb_pairwise_gravity_coulomb_force_sum_core.sv
